// ===== design/boc_pkg.sv =====
// Shared constants and types for the box overlap classifier.
`default_nettype none

package boc_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int FRAC_BITS          = 16;
   localparam int OV_BITS            = FRAC_BITS + 1;
   localparam int CSR_DATA_BITS      = OV_BITS;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int QUEUE_DEPTH        = 8;

   localparam logic [OV_BITS-1:0] ONE_FRAC             = OV_BITS'(65536);
   localparam logic [OV_BITS-1:0] GOOD_THRESHOLD_RESET = OV_BITS'(39322);
   localparam logic [OV_BITS-1:0] BAD_THRESHOLD_RESET  = OV_BITS'(13107);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REF_LEFT       = 3'd0,
      CSR_REF_TOP        = 3'd1,
      CSR_REF_WIDTH      = 3'd2,
      CSR_REF_HEIGHT     = 3'd3,
      CSR_GOOD_THRESHOLD = 3'd4,
      CSR_BAD_THRESHOLD  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_WAIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== design/boc_front.sv =====
// Front end: box edges, intersection and union areas in a four-stage pipeline.
`default_nettype none

module boc_front #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [COORD_BITS-1:0]     box_left,
   input  wire logic [COORD_BITS-1:0]     box_top,
   input  wire logic [COORD_BITS-1:0]     box_width,
   input  wire logic [COORD_BITS-1:0]     box_height,
   input  wire logic                      first_box,
   input  wire logic [COORD_BITS-1:0]     ref_left,
   input  wire logic [COORD_BITS-1:0]     ref_top,
   input  wire logic [COORD_BITS-1:0]     ref_width,
   input  wire logic [COORD_BITS-1:0]     ref_height,
   output logic                           out_valid,
   output logic [COORD_BITS-1:0]          out_left,
   output logic [COORD_BITS-1:0]          out_top,
   output logic [COORD_BITS-1:0]          out_width,
   output logic [COORD_BITS-1:0]          out_height,
   output logic                           out_first,
   output logic [2*COORD_BITS-1:0]        out_inter,
   output logic [2*COORD_BITS:0]          out_union
);

   localparam int EB = COORD_BITS + 1;
   localparam int AB = 2 * COORD_BITS;

   // stage 1: far edges
   logic                  v1_ff;
   logic [COORD_BITS-1:0] l1_ff, t1_ff, w1_ff, h1_ff;
   logic                  f1_ff;
   logic [EB-1:0]         rr_ff, rb_ff, br_ff, bb_ff;

   // stage 2: overlap extent
   logic                  v2_ff;
   logic [COORD_BITS-1:0] l2_ff, t2_ff, w2_ff, h2_ff;
   logic                  f2_ff;
   logic [COORD_BITS-1:0] cols_ff, rows_ff;
   logic [COORD_BITS-1:0] cols_in, rows_in;

   // stage 3: areas
   logic                  v3_ff;
   logic [COORD_BITS-1:0] l3_ff, t3_ff, w3_ff, h3_ff;
   logic                  f3_ff;
   logic [AB-1:0]         inter3_ff, area_ref_ff, area_box_ff;

   // stage 4: union
   logic                  v4_ff;
   logic [COORD_BITS-1:0] l4_ff, t4_ff, w4_ff, h4_ff;
   logic                  f4_ff;
   logic [AB-1:0]         inter4_ff;
   logic [AB:0]           union4_ff;

   logic                  sep;
   logic [EB-1:0]         x_lo, x_hi, y_lo, y_hi;
   logic [EB-1:0]         ref_left_x, ref_top_x;

   always_comb begin
      ref_left_x = {1'b0, ref_left};
      ref_top_x  = {1'b0, ref_top};
   end

   always_comb begin
      sep  = (ref_left_x > br_ff) || (ref_top_x > bb_ff) ||
             (rr_ff < {1'b0, l1_ff}) || (rb_ff < {1'b0, t1_ff});
      x_hi = (rr_ff < br_ff) ? rr_ff : br_ff;
      x_lo = (ref_left_x > {1'b0, l1_ff}) ? ref_left_x : {1'b0, l1_ff};
      y_hi = (rb_ff < bb_ff) ? rb_ff : bb_ff;
      y_lo = (ref_top_x > {1'b0, t1_ff}) ? ref_top_x : {1'b0, t1_ff};
      cols_in = '0;
      rows_in = '0;
      if (!sep) begin
         cols_in = COORD_BITS'(x_hi - x_lo);
         rows_in = COORD_BITS'(y_hi - y_lo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      l1_ff <= box_left;
      t1_ff <= box_top;
      w1_ff <= box_width;
      h1_ff <= box_height;
      f1_ff <= first_box;
      rr_ff <= {1'b0, ref_left} + {1'b0, ref_width};
      rb_ff <= {1'b0, ref_top} + {1'b0, ref_height};
      br_ff <= {1'b0, box_left} + {1'b0, box_width};
      bb_ff <= {1'b0, box_top} + {1'b0, box_height};

      l2_ff   <= l1_ff;
      t2_ff   <= t1_ff;
      w2_ff   <= w1_ff;
      h2_ff   <= h1_ff;
      f2_ff   <= f1_ff;
      cols_ff <= cols_in;
      rows_ff <= rows_in;

      l3_ff       <= l2_ff;
      t3_ff       <= t2_ff;
      w3_ff       <= w2_ff;
      h3_ff       <= h2_ff;
      f3_ff       <= f2_ff;
      inter3_ff   <= AB'(cols_ff) * AB'(rows_ff);
      area_ref_ff <= AB'(ref_width) * AB'(ref_height);
      area_box_ff <= AB'(w2_ff) * AB'(h2_ff);

      l4_ff     <= l3_ff;
      t4_ff     <= t3_ff;
      w4_ff     <= w3_ff;
      h4_ff     <= h3_ff;
      f4_ff     <= f3_ff;
      inter4_ff <= inter3_ff;
      // intersection never exceeds either area, so this cannot go negative
      union4_ff <= {1'b0, area_ref_ff} + {1'b0, area_box_ff} - {1'b0, inter3_ff};
   end

   assign out_valid  = v4_ff;
   assign out_left   = l4_ff;
   assign out_top    = t4_ff;
   assign out_width  = w4_ff;
   assign out_height = h4_ff;
   assign out_first  = f4_ff;
   assign out_inter  = inter4_ff;
   assign out_union  = union4_ff;

endmodule

`default_nettype wire

// ===== design/boc_queue.sv =====
// Small register FIFO between the front end and the divider back end.
`default_nettype none

module boc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   always_comb begin
      do_pop   = pop && (count_ff != '0);
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[head_ff];

   // upstream credit counting must keep the FIFO from overrunning
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && !do_pop && count_ff == CW'(DEPTH)))
      else $error("queue overrun");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");

   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ===== design/boc_back.sv =====
// Back end: bit-serial overlap divide, thresholds, running best and result register.
`default_nettype none

module boc_back #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_not_empty,
   input  wire logic [COORD_BITS-1:0]         q_left,
   input  wire logic [COORD_BITS-1:0]         q_top,
   input  wire logic [COORD_BITS-1:0]         q_width,
   input  wire logic [COORD_BITS-1:0]         q_height,
   input  wire logic                          q_first,
   input  wire logic [2*COORD_BITS-1:0]       q_inter,
   input  wire logic [2*COORD_BITS:0]         q_union,
   output logic                               q_pop,
   input  wire logic [boc_pkg::OV_BITS-1:0]   good_threshold,
   input  wire logic [boc_pkg::OV_BITS-1:0]   bad_threshold,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [boc_pkg::OV_BITS-1:0]        rsp_overlap_frac,
   output logic                               rsp_is_good,
   output logic                               rsp_is_bad,
   output logic                               rsp_became_best,
   output logic [COORD_BITS-1:0]              rsp_best_left,
   output logic [COORD_BITS-1:0]              rsp_best_top,
   output logic [COORD_BITS-1:0]              rsp_best_width,
   output logic [COORD_BITS-1:0]              rsp_best_height
);

   import boc_pkg::*;

   localparam int DW = 2 * COORD_BITS + 1;
   localparam int RW = DW + 1;
   localparam int SB = $clog2(OV_BITS);

   back_state_type        state_ff, state_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [DW-1:0]         div_ff;
   logic [OV_BITS-1:0]    quo_ff, quo_in;
   logic [SB-1:0]         step_ff, step_in;
   logic                  zero_ff;
   logic [COORD_BITS-1:0] l_ff, t_ff, w_ff, h_ff;
   logic                  first_ff;
   logic                  load;

   logic [OV_BITS-1:0]    best_ov_ff, best_ov_in;
   logic [COORD_BITS-1:0] best_l_ff, best_l_in, best_t_ff, best_t_in;
   logic [COORD_BITS-1:0] best_w_ff, best_w_in, best_h_ff, best_h_in;

   logic                  out_valid_ff, out_valid_in;
   logic [OV_BITS-1:0]    out_ov_ff;
   logic                  out_good_ff, out_bad_ff, out_best_ff;
   logic                  retire;

   logic                  ge;
   logic [RW-1:0]         diff;
   logic [OV_BITS-1:0]    ov, base_ov;
   logic                  good, bad, became;

   always_comb begin
      ge   = rem_ff >= {1'b0, div_ff};
      diff = ge ? rem_ff - {1'b0, div_ff} : rem_ff;

      ov      = zero_ff ? '0 : quo_ff;
      base_ov = first_ff ? '0 : best_ov_ff;
      good    = ov > good_threshold;
      bad     = !good && (ov < bad_threshold);
      became  = ov > base_ov;

      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      retire   = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               rem_in   = RW'(q_inter);
               quo_in   = '0;
               step_in  = SB'(OV_BITS - 1);
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            // one quotient bit per cycle, most significant first
            quo_in  = {quo_ff[OV_BITS-2:0], ge};
            rem_in  = {diff[RW-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = BK_WAIT;
            end
         end
         BK_WAIT: begin
            if (!out_valid_ff || rsp_pop) begin
               retire   = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      best_ov_in = best_ov_ff;
      best_l_in  = best_l_ff;
      best_t_in  = best_t_ff;
      best_w_in  = best_w_ff;
      best_h_in  = best_h_ff;
      if (retire) begin
         if (became) begin
            best_ov_in = ov;
            best_l_in  = l_ff;
            best_t_in  = t_ff;
            best_w_in  = w_ff;
            best_h_in  = h_ff;
         end else if (first_ff) begin
            best_ov_in = '0;
            best_l_in  = '0;
            best_t_in  = '0;
            best_w_in  = '0;
            best_h_in  = '0;
         end
      end

      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (retire) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
         best_ov_ff   <= '0;
         best_l_ff    <= '0;
         best_t_ff    <= '0;
         best_w_ff    <= '0;
         best_h_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         best_ov_ff   <= best_ov_in;
         best_l_ff    <= best_l_in;
         best_t_ff    <= best_t_in;
         best_w_ff    <= best_w_in;
         best_h_ff    <= best_h_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (load) begin
         div_ff   <= q_union;
         zero_ff  <= (q_union == '0);
         l_ff     <= q_left;
         t_ff     <= q_top;
         w_ff     <= q_width;
         h_ff     <= q_height;
         first_ff <= q_first;
      end
      if (retire) begin
         out_ov_ff   <= ov;
         out_good_ff <= good;
         out_bad_ff  <= bad;
         out_best_ff <= became;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_overlap_frac = out_ov_ff;
   assign rsp_is_good      = out_good_ff;
   assign rsp_is_bad       = out_bad_ff;
   assign rsp_became_best  = out_best_ff;
   assign rsp_best_left    = best_l_ff;
   assign rsp_best_top     = best_t_ff;
   assign rsp_best_width   = best_w_ff;
   assign rsp_best_height  = best_h_ff;

   a_ov_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ov_ff <= ONE_FRAC)
      else $error("overlap above one");

   a_best_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_best_ff) |-> out_ov_ff != '0)
      else $error("zero overlap became best");

   a_best_box_consistent: assert property (@(posedge clock) disable iff (reset)
      (best_ov_ff == '0) == (best_w_ff == '0))
      else $error("best record and best box disagree");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE) |-> rem_ff <= {div_ff, 1'b0})
      else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== design/box_overlap_classifier.sv =====
// Top level: register file, credit count, front end, queue and back end.
// An accepted request passes the four front stages, a queue write, a divider load,
// the bit-serial divide and a retire before its response; a stall holds it longer.
// The divider takes a new transaction only after it has retired the last one.
// Up to QUEUE_DEPTH requests are taken ahead of the divider.
// Reset (synchronous, active high) empties both sides, clears the running best
// and loads the register defaults.
`default_nettype none

module box_overlap_classifier #(
   parameter int COORD_BITS = boc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [COORD_BITS-1:0]               req_box_left,
   input  wire logic [COORD_BITS-1:0]               req_box_top,
   input  wire logic [COORD_BITS-1:0]               req_box_width,
   input  wire logic [COORD_BITS-1:0]               req_box_height,
   input  wire logic                                req_first_box,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [boc_pkg::OV_BITS-1:0]              rsp_overlap_frac,
   output logic                                     rsp_is_good,
   output logic                                     rsp_is_bad,
   output logic                                     rsp_became_best,
   output logic [COORD_BITS-1:0]                    rsp_best_left,
   output logic [COORD_BITS-1:0]                    rsp_best_top,
   output logic [COORD_BITS-1:0]                    rsp_best_width,
   output logic [COORD_BITS-1:0]                    rsp_best_height,
   input  wire logic                                csr_wr_en,
   input  wire logic [boc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [boc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import boc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int QW = 8 * C + 2;
   localparam int OW = $clog2(QUEUE_DEPTH + 1);

   logic [C-1:0]       ref_left_ff, ref_top_ff, ref_width_ff, ref_height_ff;
   logic [OV_BITS-1:0] good_thr_ff, bad_thr_ff;
   logic [OW-1:0]      occ_ff, occ_in;
   logic               accept;

   logic               f_valid;
   logic [C-1:0]       f_left, f_top, f_width, f_height;
   logic               f_first;
   logic [2*C-1:0]     f_inter;
   logic [2*C:0]       f_union;

   logic               q_not_empty, q_pop;
   logic [QW-1:0]      q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_left_ff   <= '0;
         ref_top_ff    <= '0;
         ref_width_ff  <= C'(1);
         ref_height_ff <= C'(1);
         good_thr_ff   <= GOOD_THRESHOLD_RESET;
         bad_thr_ff    <= BAD_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REF_LEFT:       ref_left_ff   <= csr_data[C-1:0];
            CSR_REF_TOP:        ref_top_ff    <= csr_data[C-1:0];
            CSR_REF_WIDTH:      ref_width_ff  <= csr_data[C-1:0];
            CSR_REF_HEIGHT:     ref_height_ff <= csr_data[C-1:0];
            CSR_GOOD_THRESHOLD: good_thr_ff   <= csr_data[OV_BITS-1:0];
            CSR_BAD_THRESHOLD:  bad_thr_ff    <= csr_data[OV_BITS-1:0];
            default: ;
         endcase
      end
   end

   // credits cover items in the front pipeline plus items in the queue
   always_comb begin
      accept = req_push && !req_full;
      occ_in = occ_ff;
      if (accept && !q_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (!accept && q_pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign req_full = (occ_ff == OW'(QUEUE_DEPTH));

   boc_front #(
      .COORD_BITS (C)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .box_left   (req_box_left),
      .box_top    (req_box_top),
      .box_width  (req_box_width),
      .box_height (req_box_height),
      .first_box  (req_first_box),
      .ref_left   (ref_left_ff),
      .ref_top    (ref_top_ff),
      .ref_width  (ref_width_ff),
      .ref_height (ref_height_ff),
      .out_valid  (f_valid),
      .out_left   (f_left),
      .out_top    (f_top),
      .out_width  (f_width),
      .out_height (f_height),
      .out_first  (f_first),
      .out_inter  (f_inter),
      .out_union  (f_union)
   );

   boc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data ({f_left, f_top, f_width, f_height, f_first, f_inter, f_union}),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   boc_back #(
      .COORD_BITS (C)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_left           (q_head[8*C+1:7*C+2]),
      .q_top            (q_head[7*C+1:6*C+2]),
      .q_width          (q_head[6*C+1:5*C+2]),
      .q_height         (q_head[5*C+1:4*C+2]),
      .q_first          (q_head[4*C+1]),
      .q_inter          (q_head[4*C:2*C+1]),
      .q_union          (q_head[2*C:0]),
      .q_pop            (q_pop),
      .good_threshold   (good_thr_ff),
      .bad_threshold    (bad_thr_ff),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_overlap_frac (rsp_overlap_frac),
      .rsp_is_good      (rsp_is_good),
      .rsp_is_bad       (rsp_is_bad),
      .rsp_became_best  (rsp_became_best),
      .rsp_best_left    (rsp_best_left),
      .rsp_best_top     (rsp_best_top),
      .rsp_best_width   (rsp_best_width),
      .rsp_best_height  (rsp_best_height)
   );

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(QUEUE_DEPTH))
      else $error("credit count out of range");

   a_pop_has_credit: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> occ_ff != '0)
      else $error("queue pop without a credit");

   a_back_queue: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire
